// ===== sv/euq_pkg.sv =====
`timescale 1ns / 1ps
package euq_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int COMP_BITS  = 16;
  localparam int STEPS      = 32;
  localparam int CW         = 34;
  localparam int FW         = 32;
  localparam int PW         = 34;
  localparam int TW         = 36;
  localparam int LANE_LAT   = STEPS + 3;
  localparam int MERGE_LAT  = 3;
  localparam int RND_SH     = 31 - COMP_BITS;

  localparam logic [31:0]          PI_Q30      = 32'd3373259426;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef logic [2:0] order_t;
  localparam order_t ORD_XYZ = 3'd0;
  localparam order_t ORD_XZY = 3'd1;
  localparam order_t ORD_YXZ = 3'd2;
  localparam order_t ORD_YZX = 3'd3;
  localparam order_t ORD_ZXY = 3'd4;
  localparam order_t ORD_ZYX = 3'd5;

  typedef logic signed [FW-1:0] fac_t;
  typedef logic signed [COMP_BITS-1:0] comp_t;

  typedef struct packed {
    fac_t c;
    fac_t s;
  } cs_t;

  function automatic logic signed [CW-1:0] atan_q30(input int i);
    logic signed [CW-1:0] v;
    case (i)
      0:  v = 34'sd843314856;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043836;
      3:  v = 34'sd133525158;
      4:  v = 34'sd67021686;
      5:  v = 34'sd33543515;
      6:  v = 34'sd16775850;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194282;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048575;
      11: v = 34'sd524287;
      12: v = 34'sd262143;
      13: v = 34'sd131071;
      14: v = 34'sd65535;
      15: v = 34'sd32767;
      16: v = 34'sd16383;
      17: v = 34'sd8191;
      18: v = 34'sd4095;
      19: v = 34'sd2047;
      20: v = 34'sd1023;
      21: v = 34'sd511;
      22: v = 34'sd255;
      23: v = 34'sd127;
      24: v = 34'sd63;
      25: v = 34'sd31;
      26: v = 34'sd15;
      27: v = 34'sd8;
      28: v = 34'sd4;
      29: v = 34'sd2;
      30: v = 34'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // bit k set: second term of component k (w, x, y, z) is subtracted
  function automatic logic [3:0] neg_mask(input order_t o);
    logic [3:0] m;
    case (o)
      ORD_XYZ: m = 4'b0101;
      ORD_XZY: m = 4'b0110;
      ORD_YXZ: m = 4'b1100;
      ORD_YZX: m = 4'b1001;
      ORD_ZXY: m = 4'b0011;
      ORD_ZYX: m = 4'b1010;
      default: m = 4'b0000;
    endcase
    return m;
  endfunction

endpackage

// ===== sv/euler_to_quaternion_unit.sv =====
`timescale 1ns / 1ps
// Euler angles to quaternion.
// Input: pulse start with in_angle_x/y/z (binary angles, 2^16 per turn) and
// in_order (0 XYZ, 1 XZY, 2 YXZ, 3 YZX, 4 ZXY, 5 ZYX, 6/7 identity).
// A beat is taken at every edge where start is high and busy is low; busy
// is always low, so one beat per cycle is accepted.
// Output: out_valid strobes for one cycle with out_quat_w/x/y/z, signed
// Q1.15, saturated at +1.
// From accept to strobe, a beat passes three parallel CORDIC lanes (input
// register, angle scaling multiply, 32 rotation stages, quadrant fold)
// followed by a three-stage merge (pair products, triple products,
// sign/round/saturate).
// Throughput: one quaternion per cycle, every cycle.
// Reset clears the valid pipeline; items in flight are dropped.
// The receiver cannot stall; results are never held back.
module euler_to_quaternion_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [euq_pkg::ANGLE_BITS-1:0] in_angle_x,
  input  logic [euq_pkg::ANGLE_BITS-1:0] in_angle_y,
  input  logic [euq_pkg::ANGLE_BITS-1:0] in_angle_z,
  input  euq_pkg::order_t                in_order,
  output logic                           out_valid,
  output euq_pkg::comp_t                 out_quat_w,
  output euq_pkg::comp_t                 out_quat_x,
  output euq_pkg::comp_t                 out_quat_y,
  output euq_pkg::comp_t                 out_quat_z
);
  import euq_pkg::*;

  logic [LANE_LAT-1:0] vld_r;
  order_t              ord_r [0:LANE_LAT-1];
  cs_t                 cs_x, cs_y, cs_z;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LANE_LAT-2:0], start & ~busy};
    end
  end

  always_ff @(posedge clk) begin
    ord_r[0] <= in_order;
  end

  for (genvar i = 1; i < LANE_LAT; i++) begin : g_ord
    always_ff @(posedge clk) begin
      ord_r[i] <= ord_r[i-1];
    end
  end

  euq_cordic_lane u_lane_x (.clk(clk), .angle(in_angle_x), .cs(cs_x));
  euq_cordic_lane u_lane_y (.clk(clk), .angle(in_angle_y), .cs(cs_y));
  euq_cordic_lane u_lane_z (.clk(clk), .angle(in_angle_z), .cs(cs_z));

  euq_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid     (vld_r[LANE_LAT-1]),
    .order     (ord_r[LANE_LAT-1]),
    .cs_x      (cs_x),
    .cs_y      (cs_y),
    .cs_z      (cs_z),
    .out_valid (out_valid),
    .quat_w    (out_quat_w),
    .quat_x    (out_quat_x),
    .quat_y    (out_quat_y),
    .quat_z    (out_quat_z)
  );
endmodule

// ===== sv/euq_cordic_lane.sv =====
`timescale 1ns / 1ps
module euq_cordic_lane (
  input  logic                            clk,
  input  logic [euq_pkg::ANGLE_BITS-1:0]  angle,
  output euq_pkg::cs_t                    cs
);
  import euq_pkg::*;

  localparam int RB = ANGLE_BITS - 1;

  logic [RB-1:0]          r_r;
  logic                   q_r [0:STEPS+1];
  logic [RB+31:0]         zprod;
  logic signed [CW-1:0]   x_r [0:STEPS];
  logic signed [CW-1:0]   y_r [0:STEPS];
  logic signed [CW-1:0]   z_r [0:STEPS];
  cs_t                    cs_r;

  assign zprod = {{32{1'b0}}, r_r} * {{RB{1'b0}}, PI_Q30};

  always_ff @(posedge clk) begin
    q_r[0] <= angle[ANGLE_BITS-1];
    r_r    <= angle[RB-1:0];
    q_r[1] <= q_r[0];
    x_r[0] <= CORDIC_GAIN;
    y_r[0] <= '0;
    z_r[0] <= CW'($signed({1'b0, zprod[RB+31:ANGLE_BITS]}));
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      q_r[i+2] <= q_r[i+1];
      if (!z_r[i][CW-1]) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - atan_q30(i);
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + atan_q30(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_r[STEPS+1]) begin
      cs_r.c <= FW'(-y_r[STEPS]);
      cs_r.s <= FW'(x_r[STEPS]);
    end else begin
      cs_r.c <= FW'(x_r[STEPS]);
      cs_r.s <= FW'(y_r[STEPS]);
    end
  end

  assign cs = cs_r;
endmodule

// ===== sv/euq_merge.sv =====
`timescale 1ns / 1ps
module euq_merge (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  valid,
  input  euq_pkg::order_t       order,
  input  euq_pkg::cs_t          cs_x,
  input  euq_pkg::cs_t          cs_y,
  input  euq_pkg::cs_t          cs_z,
  output logic                  out_valid,
  output euq_pkg::comp_t        quat_w,
  output euq_pkg::comp_t        quat_x,
  output euq_pkg::comp_t        quat_y,
  output euq_pkg::comp_t        quat_z
);
  import euq_pkg::*;

  localparam int VW = TW + 1;
  localparam logic signed [VW-1:0] CMAX = VW'((1 <<< (COMP_BITS - 1)) - 1);
  localparam logic signed [VW-1:0] CMIN = -CMAX - VW'(1);
  localparam comp_t ONE_SAT = comp_t'((1 <<< (COMP_BITS - 1)) - 1);

  function automatic comp_t round_sat(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] r;
    r = (v + VW'(1 <<< (RND_SH - 1))) >>> RND_SH;
    if (r > CMAX) r = CMAX;
    if (r < CMIN) r = CMIN;
    return r[COMP_BITS-1:0];
  endfunction

  logic [MERGE_LAT-1:0] vld_r;
  order_t               ord_r [0:MERGE_LAT-2];

  logic signed [2*FW-1:0] m_cc, m_ss, m_sc, m_cs;
  logic signed [PW-1:0]   p_cc_r, p_ss_r, p_sc_r, p_cs_r;
  fac_t                   cz_r, sz_r;

  logic signed [PW+FW-1:0] t [0:7];
  logic signed [TW-1:0]    t_r [0:7];
  logic [3:0]              neg;
  logic signed [VW-1:0]    v [0:3];
  comp_t                   q_r [0:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[MERGE_LAT-2:0], valid};
    end
  end

  always_ff @(posedge clk) begin
    ord_r[0] <= order;
    ord_r[1] <= ord_r[0];
  end

  assign m_cc = cs_x.c * cs_y.c;
  assign m_ss = cs_x.s * cs_y.s;
  assign m_sc = cs_x.s * cs_y.c;
  assign m_cs = cs_x.c * cs_y.s;

  always_ff @(posedge clk) begin
    p_cc_r <= m_cc[2*FW-1:30];
    p_ss_r <= m_ss[2*FW-1:30];
    p_sc_r <= m_sc[2*FW-1:30];
    p_cs_r <= m_cs[2*FW-1:30];
    cz_r   <= cs_z.c;
    sz_r   <= cs_z.s;
  end

  assign t[0] = p_cc_r * cz_r;
  assign t[1] = p_ss_r * sz_r;
  assign t[2] = p_sc_r * cz_r;
  assign t[3] = p_cs_r * sz_r;
  assign t[4] = p_cs_r * cz_r;
  assign t[5] = p_sc_r * sz_r;
  assign t[6] = p_cc_r * sz_r;
  assign t[7] = p_ss_r * cz_r;

  for (genvar k = 0; k < 8; k++) begin : g_trip
    always_ff @(posedge clk) begin
      t_r[k] <= t[k][PW+FW-1:30];
    end
  end

  assign neg = neg_mask(ord_r[1]);

  for (genvar k = 0; k < 4; k++) begin : g_comp
    assign v[k] = neg[k] ? (VW'(t_r[2*k]) - VW'(t_r[2*k+1]))
                         : (VW'(t_r[2*k]) + VW'(t_r[2*k+1]));
    always_ff @(posedge clk) begin
      if (ord_r[1] > ORD_ZYX) begin
        q_r[k] <= (k == 0) ? ONE_SAT : '0;
      end else begin
        q_r[k] <= round_sat(v[k]);
      end
    end
  end

  assign out_valid = vld_r[MERGE_LAT-1];
  assign quat_w = q_r[0];
  assign quat_x = q_r[1];
  assign quat_y = q_r[2];
  assign quat_z = q_r[3];
endmodule

// ===== test/euler_to_quaternion_unit_tb.sv =====
`timescale 1ns / 1ps
module euler_to_quaternion_unit_tb;
  import euq_pkg::*;

  localparam int PIPE_LAT = 38;
  localparam int WATCHDOG_MAX = 4000;

  typedef struct {
    logic [15:0] w;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
  } quat_t;

  localparam longint ROT_TABLE [32] = '{
    843314856, 497837829, 263043836, 133525158, 67021686,
    33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
    524287, 262143, 131071, 65535, 32767, 16383, 8191,
    4095, 2047, 1023, 511, 255, 127, 63, 31, 15, 8, 4, 2, 1, 0};

  class quat_scoreboard;
    quat_t pending[$];
    int mismatches;

    function void half_angle_trig(input logic [15:0] a, output longint c,
                                  output longint s);
      longint xr, yr, zr, nx;
      logic [63:0] r;
      xr = 652032874;
      yr = 0;
      r = {49'd0, a[14:0]};
      zr = longint'((r * 64'd3373259426) >> 16);
      for (int i = 0; i < 32; i++) begin
        if (zr >= 0) begin
          nx = xr - (yr >>> i);
          yr = yr + (xr >>> i);
          zr -= ROT_TABLE[i];
        end else begin
          nx = xr + (yr >>> i);
          yr = yr - (xr >>> i);
          zr += ROT_TABLE[i];
        end
        xr = nx;
      end
      if (a[15]) begin
        c = -yr;
        s = xr;
      end else begin
        c = xr;
        s = yr;
      end
    endfunction

    function longint triple(input longint a, input longint b, input longint c);
      longint t;
      t = (a * b) >>> 30;
      return (t * c) >>> 30;
    endfunction

    function logic [15:0] round_sat(input longint v);
      longint r;
      r = (v + (longint'(1) << (RND_SH - 1))) >>> RND_SH;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
    endfunction

    function void note_input(input logic [15:0] ax, input logic [15:0] ay,
                             input logic [15:0] az, input order_t ord);
      longint cx, sx, cy, sy, cz, sz;
      longint p1[4], p2[4], v;
      logic [3:0] neg;
      logic [15:0] comp[4];
      quat_t q;
      case (ord)
        ORD_XYZ: neg = 4'b0101;
        ORD_XZY: neg = 4'b0110;
        ORD_YXZ: neg = 4'b1100;
        ORD_YZX: neg = 4'b1001;
        ORD_ZXY: neg = 4'b0011;
        ORD_ZYX: neg = 4'b1010;
        default: neg = 4'b0000;
      endcase
      if (ord > ORD_ZYX) begin
        q.w = 16'h7fff;
        q.x = '0;
        q.y = '0;
        q.z = '0;
      end else begin
        half_angle_trig(ax, cx, sx);
        half_angle_trig(ay, cy, sy);
        half_angle_trig(az, cz, sz);
        p1[0] = triple(cx, cy, cz);
        p2[0] = triple(sx, sy, sz);
        p1[1] = triple(sx, cy, cz);
        p2[1] = triple(cx, sy, sz);
        p1[2] = triple(cx, sy, cz);
        p2[2] = triple(sx, cy, sz);
        p1[3] = triple(cx, cy, sz);
        p2[3] = triple(sx, sy, cz);
        for (int k = 0; k < 4; k++) begin
          v = neg[k] ? p1[k] - p2[k] : p1[k] + p2[k];
          comp[k] = round_sat(v);
        end
        q.w = comp[0];
        q.x = comp[1];
        q.y = comp[2];
        q.z = comp[3];
      end
      pending.push_back(q);
    endfunction

    function void check_result(input quat_t got);
      quat_t exp_q;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat w=%h", got.w);
        return;
      end
      exp_q = pending.pop_front();
      if (got.w !== exp_q.w || got.x !== exp_q.x || got.y !== exp_q.y ||
          got.z !== exp_q.z) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp %h %h %h %h got %h %h %h %h", exp_q.w, exp_q.x,
                   exp_q.y, exp_q.z, got.w, got.x, got.y, got.z);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [15:0] in_angle_x = '0, in_angle_y = '0, in_angle_z = '0;
  order_t in_order = '0;
  logic out_valid;
  comp_t out_quat_w, out_quat_x, out_quat_y, out_quat_z;

  quat_scoreboard sb = new();
  int idle_pct = 0;
  int quiet_cycles = 0;

  always #2 clk = ~clk;

  euler_to_quaternion_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_angle_x(in_angle_x), .in_angle_y(in_angle_y), .in_angle_z(in_angle_z),
    .in_order(in_order), .out_valid(out_valid), .out_quat_w(out_quat_w),
    .out_quat_x(out_quat_x), .out_quat_y(out_quat_y), .out_quat_z(out_quat_z)
  );

  always @(posedge clk) begin
    quat_t got;
    if (rst_n) begin
      if (start && !busy) begin
        sb.note_input(in_angle_x, in_angle_y, in_angle_z, in_order);
      end
      if (out_valid) begin
        got.w = out_quat_w;
        got.x = out_quat_x;
        got.y = out_quat_y;
        got.z = out_quat_z;
        sb.check_result(got);
      end
      if ((start && !busy) || out_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("euler_to_quaternion_unit_tb NOT OK");
        $finish;
      end
    end
  end

  task automatic send_angles(input logic [15:0] ax, input logic [15:0] ay,
                             input logic [15:0] az, input order_t ord);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_angle_x <= ax;
    in_angle_y <= ay;
    in_angle_z <= az;
    in_order <= ord;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(5))
      0: return 16'(($urandom_range(7)) << 13);
      1: return 16'(($urandom_range(7) << 13) + $urandom_range(2) - 1);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] corners[8];
    corners = '{16'h0000, 16'hffff, 16'h8000, 16'h7fff,
                16'h4000, 16'hc000, 16'h0001, 16'h2000};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int o = 0; o < 8; o++) begin
      send_angles(corners[o], corners[(o + 3) % 8], corners[(o + 5) % 8], order_t'(o));
    end
    for (int i = 0; i < 8; i++) begin
      send_angles(corners[i], corners[i], corners[i], order_t'(i % 6));
    end
    send_angles(16'h2000, 16'h2000, 16'h2000, ORD_XYZ);
    send_angles(16'h5555, 16'haaaa, 16'h3333, ORD_ZYX);
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 0) ? 0 : (ph == 2) ? 0 : (ph == 1) ? 53 : 35;
      for (int i = 0; i < 375; i++) begin
        send_angles(pick_angle(), pick_angle(), pick_angle(),
                    order_t'($urandom_range(9) < 8 ? $urandom_range(5) : $urandom_range(7)));
      end
      if (ph == 1) begin
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
      end
    end
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("euler_to_quaternion_unit_tb OK");
    end else begin
      $display("euler_to_quaternion_unit_tb NOT OK");
    end
    $finish;
  end
endmodule

// ===== files.f =====
sv/euq_pkg.sv
sv/euq_cordic_lane.sv
sv/euq_merge.sv
sv/euler_to_quaternion_unit.sv
test/euler_to_quaternion_unit_tb.sv
